// ===== hw/rtl/cycloid_swing_trajectory_top_macros.svh =====
// Assertion macros shared by the cycloid swing trajectory RTL
`ifndef CYCLOID_SWING_TRAJECTORY_TOP_MACROS_SVH
`define CYCLOID_SWING_TRAJECTORY_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CST_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");

// Implication after a fixed number of cycles, disabled while reset is high
`define CST_ASSERT_DELAY(label, clk, rst, pre, n, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error("assertion failed: delayed implication");

`endif

// ===== hw/rtl/cst_pkg.sv =====
// Types, constants and table functions for the cycloid swing trajectory
package cst_pkg;

   localparam int PHASE_BITS_DEF       = 16;
   localparam int SINE_TABLE_DEPTH_DEF = 256;
   localparam int LATENCY              = 6;

   localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
   localparam logic [31:0] PI_Q30        = 32'd3373259426;
   localparam logic [29:0] INV_2PI_Q32   = 30'd683565276;
   localparam logic [31:0] ONE_Q30       = 32'd1073741824;
   localparam logic [23:0] SWING_RATE_RST = 24'd291271;

   typedef enum logic [0:0] {
      CSR_SWING_HEIGHT = 1'b0,
      CSR_SWING_RATE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        phase;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } rsp_type;

   // Folded sine / cosine for one phase
   typedef struct packed {
      logic        s_neg;
      logic [30:0] s_mag;
      logic [31:0] omc;     // 1 - cos, unsigned Q30
   } trig_type;

   // Sine of angle x (Q30), truncating Taylor series, clamped to [0, 1]
   function automatic logic [30:0] sine_entry(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(64'(ONE_Q30))) begin
         sum = $signed(64'(ONE_Q30));
      end
      return 31'(sum);
   endfunction

   // Apply a sign to a magnitude
   function automatic logic signed [47:0] apply_sign(input logic neg, input logic [46:0] mag);
      logic signed [47:0] v;
      v = $signed({1'b0, mag});
      return neg ? -v : v;
   endfunction

   // Clamp to the int32 range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

endpackage

// ===== hw/rtl/cst_sine_lut.sv =====
// Quarter-wave sine table with quadrant folding for sine and 1 - cosine
module cst_sine_lut #(
   parameter int SINE_TABLE_DEPTH = cst_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int IDX_BITS         = $clog2(SINE_TABLE_DEPTH + 1)
) (
   input  logic [1:0]          quad,
   input  logic [IDX_BITS-1:0] idx,
   output cst_pkg::trig_type   trig
);
   import cst_pkg::*;

   logic [30:0]         sin_tab [SINE_TABLE_DEPTH+1];
   logic [IDX_BITS-1:0] s_idx;
   logic [IDX_BITS-1:0] c_idx;
   logic [30:0]         c_mag;
   logic                c_neg;

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
      localparam logic [63:0] X = (64'(i) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2))
                                  / 64'(SINE_TABLE_DEPTH);
      assign sin_tab[i] = sine_entry(X);
   end

   // Odd quadrants read the table backwards; cosine is sine one quadrant on
   always_comb begin
      s_idx = quad[0] ? IDX_BITS'(SINE_TABLE_DEPTH) - idx : idx;
      c_idx = quad[0] ? idx : IDX_BITS'(SINE_TABLE_DEPTH) - idx;
      c_mag = sin_tab[c_idx];
      c_neg = quad[1] ^ quad[0];
      trig.s_neg = quad[1];
      trig.s_mag = sin_tab[s_idx];
      trig.omc   = c_neg ? ONE_Q30 + 32'(c_mag) : ONE_Q30 - 32'(c_mag);
   end

endmodule

// ===== hw/rtl/cycloid_swing_trajectory_top.sv =====
// Top level of the cycloid swing foot trajectory pipeline
//
//  channel    ports                              direction  handshake
//  ---------  ---------------------------------  ---------  --------------------------
//  request    start, busy, req_data              in         start && !busy
//  response   rsp_valid, rsp_data                out        strobe, one cycle, no stall
//  registers  csr_we, csr_index, csr_wdata       in         csr_we, no wait
//
// One transaction enters per cycle while busy is low; the result passes through
// six register stages: index, table lookup, first products, partial-product
// sums, position products, final add and saturation. Synchronous reset clears the
// valid bits and height and loads rate with its reset value; busy is high only during
// reset. The receiver cannot stall, so nothing in the pipeline holds.
`include "cycloid_swing_trajectory_top_macros.svh"

module cycloid_swing_trajectory_top #(
   parameter int PHASE_BITS       = cst_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = cst_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cst_pkg::req_type      req_data,
   output logic                  rsp_valid,
   output cst_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  cst_pkg::csr_index_type csr_index,
   input  logic [30:0]           csr_wdata
);
   import cst_pkg::*;

   localparam int RW  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int RSW = PHASE_BITS + RW - 1;

   // stage payloads
   typedef struct packed {
      logic [PHASE_BITS-1:0] ph;
      logic [1:0]            quad;
      logic [RW-1:0]         idx;
      logic [32:0]           dx_mag;
      logic                  dx_neg;
      logic [32:0]           dy_mag;
      logic                  dy_neg;
      logic signed [31:0]    start_x;
      logic signed [31:0]    start_y;
      logic signed [31:0]    start_z;
   } s1_type;

   typedef struct packed {
      logic [30:0]        phq;
      trig_type           trig;
      logic [41:0]        ax;
      logic [41:0]        ay;
      logic [39:0]        za;
      logic [32:0]        dx_mag;
      logic               dx_neg;
      logic [32:0]        dy_mag;
      logic               dy_neg;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
   } s2_type;

   typedef struct packed {
      logic [30:0]        phq;
      logic               s_neg;
      logic [30:0]        s_mag;
      logic [27:0]        sm;
      logic [31:0]        pz;
      logic [52:0]        vx_hi;
      logic [52:0]        vx_lo;
      logic [52:0]        vy_hi;
      logic [52:0]        vy_lo;
      logic [51:0]        zb_hi;
      logic [51:0]        zb_lo;
      logic [32:0]        dx_mag;
      logic               dx_neg;
      logic [32:0]        dy_mag;
      logic               dy_neg;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
   } s3_type;

   typedef struct packed {
      logic signed [31:0] f;
      logic [41:0]        zb;
      logic               s_neg;
      logic [30:0]        s_mag;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [32:0]        dx_mag;
      logic               dx_neg;
      logic [32:0]        dy_mag;
      logic               dy_neg;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
   } s4_type;

   typedef struct packed {
      logic signed [35:0] px;
      logic signed [35:0] py;
      logic [51:0]        vz_hi;
      logic [51:0]        vz_lo;
      logic               s_neg;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
   } s5_type;

   logic [30:0] height_ff, height_in;
   logic [23:0] rate_ff, rate_in;
   logic [LATENCY-1:0] vld_ff, vld_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   rsp_type rsp_ff, rsp_in;

   trig_type trig;

   logic [PHASE_BITS-1:0] ph;
   logic [RSW-1:0]        r_sum;
   logic signed [32:0]    dx, dy;
   logic [31:0]           f_mag_w;
   logic [63:0]           px_prod, py_prod;
   logic [74:0]           vx_sum, vy_sum;
   logic [72:0]           zb_sum;
   logic [73:0]           vz_sum;

   assign busy = reset;

   // Configuration registers
   always_comb begin
      height_in = height_ff;
      rate_in   = rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SWING_HEIGHT: height_in = csr_wdata;
            CSR_SWING_RATE:   rate_in   = csr_wdata[23:0];
            default:          height_in = height_ff;
         endcase
      end
   end

   // Valid bits advance one stage a cycle
   assign vld_in = {vld_ff[LATENCY-2:0], start & ~busy};

   // Stage 1: phase split, table index, coordinate differences
   always_comb begin
      ph    = PHASE_BITS'(req_data.phase);
      r_sum = RSW'(ph[PHASE_BITS-3:0]) * RSW'(SINE_TABLE_DEPTH)
              + (RSW'(1) << (PHASE_BITS - 3));
      dx = 33'(req_data.end_x) - 33'(req_data.start_x);
      dy = 33'(req_data.end_y) - 33'(req_data.start_y);
      s1_in.ph      = ph;
      s1_in.quad    = ph[PHASE_BITS-1:PHASE_BITS-2];
      s1_in.idx     = RW'(r_sum >> (PHASE_BITS - 2));
      s1_in.dx_neg  = dx[32];
      s1_in.dx_mag  = dx[32] ? 33'(-dx) : 33'(dx);
      s1_in.dy_neg  = dy[32];
      s1_in.dy_mag  = dy[32] ? 33'(-dy) : 33'(dy);
      s1_in.start_x = req_data.start_x;
      s1_in.start_y = req_data.start_y;
      s1_in.start_z = req_data.start_z;
   end

   cst_sine_lut #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .IDX_BITS        (RW)
   ) u_lut (
      .quad(s1_ff.quad),
      .idx (s1_ff.idx),
      .trig(trig)
   );

   // Stage 2: trig lookup, difference times rate, height times rate
   always_comb begin
      s2_in.phq     = 31'(s1_ff.ph) << (30 - PHASE_BITS);
      s2_in.trig    = trig;
      s2_in.ax      = 42'((57'(s1_ff.dx_mag) * 57'(rate_ff) + 57'd32768) >> 16);
      s2_in.ay      = 42'((57'(s1_ff.dy_mag) * 57'(rate_ff) + 57'd32768) >> 16);
      s2_in.za      = 40'((55'(height_ff) * 55'(rate_ff) + 55'd32768) >> 16);
      s2_in.dx_mag  = s1_ff.dx_mag;
      s2_in.dx_neg  = s1_ff.dx_neg;
      s2_in.dy_mag  = s1_ff.dy_mag;
      s2_in.dy_neg  = s1_ff.dy_neg;
      s2_in.start_x = s1_ff.start_x;
      s2_in.start_y = s1_ff.start_y;
      s2_in.start_z = s1_ff.start_z;
   end

   // Stage 3: sine over 2 pi, lift, and partial products of the wide terms
   always_comb begin
      s3_in.phq     = s2_ff.phq;
      s3_in.s_neg   = s2_ff.trig.s_neg;
      s3_in.s_mag   = s2_ff.trig.s_mag;
      s3_in.sm      = 28'((61'(s2_ff.trig.s_mag) * 61'(INV_2PI_Q32)
                           + (61'(1) << 31)) >> 32);
      s3_in.pz      = 32'((63'(height_ff) * 63'(s2_ff.trig.omc) + (63'(1) << 30)) >> 31);
      s3_in.vx_hi   = 53'(s2_ff.ax[41:21]) * 53'(s2_ff.trig.omc);
      s3_in.vx_lo   = 53'(s2_ff.ax[20:0]) * 53'(s2_ff.trig.omc);
      s3_in.vy_hi   = 53'(s2_ff.ay[41:21]) * 53'(s2_ff.trig.omc);
      s3_in.vy_lo   = 53'(s2_ff.ay[20:0]) * 53'(s2_ff.trig.omc);
      s3_in.zb_hi   = 52'(s2_ff.za[39:20]) * 52'(PI_Q30);
      s3_in.zb_lo   = 52'(s2_ff.za[19:0]) * 52'(PI_Q30);
      s3_in.dx_mag  = s2_ff.dx_mag;
      s3_in.dx_neg  = s2_ff.dx_neg;
      s3_in.dy_mag  = s2_ff.dy_mag;
      s3_in.dy_neg  = s2_ff.dy_neg;
      s3_in.start_x = s2_ff.start_x;
      s3_in.start_y = s2_ff.start_y;
      s3_in.start_z = s2_ff.start_z;
   end

   // Stage 4: lateral factor, z position, x/y velocity, pi*h*rate
   always_comb begin
      vx_sum = (75'(s3_ff.vx_hi) << 21) + 75'(s3_ff.vx_lo) + (75'(1) << 29);
      vy_sum = (75'(s3_ff.vy_hi) << 21) + 75'(s3_ff.vy_lo) + (75'(1) << 29);
      zb_sum = (73'(s3_ff.zb_hi) << 20) + 73'(s3_ff.zb_lo) + (73'(1) << 29);
      s4_in.f = s3_ff.s_neg ? $signed(32'(s3_ff.phq) + 32'(s3_ff.sm))
                            : $signed(32'(s3_ff.phq) - 32'(s3_ff.sm));
      s4_in.zb      = 42'(zb_sum >> 30);
      s4_in.s_neg   = s3_ff.s_neg;
      s4_in.s_mag   = s3_ff.s_mag;
      s4_in.pos_z   = sat32(48'(s3_ff.start_z) + $signed(48'(s3_ff.pz)));
      s4_in.vel_x   = sat32(apply_sign(s3_ff.dx_neg, 47'(vx_sum >> 30)));
      s4_in.vel_y   = sat32(apply_sign(s3_ff.dy_neg, 47'(vy_sum >> 30)));
      s4_in.dx_mag  = s3_ff.dx_mag;
      s4_in.dx_neg  = s3_ff.dx_neg;
      s4_in.dy_mag  = s3_ff.dy_mag;
      s4_in.dy_neg  = s3_ff.dy_neg;
      s4_in.start_x = s3_ff.start_x;
      s4_in.start_y = s3_ff.start_y;
   end

   // Stage 5: difference times lateral factor, partial products of z velocity
   always_comb begin
      f_mag_w = s4_ff.f[31] ? 32'(-s4_ff.f) : 32'(s4_ff.f);
      px_prod = 64'(s4_ff.dx_mag) * 64'(f_mag_w);
      py_prod = 64'(s4_ff.dy_mag) * 64'(f_mag_w);
      s5_in.px = 36'(apply_sign(s4_ff.dx_neg ^ s4_ff.f[31],
                                47'((px_prod + (64'(1) << 29)) >> 30)));
      s5_in.py = 36'(apply_sign(s4_ff.dy_neg ^ s4_ff.f[31],
                                47'((py_prod + (64'(1) << 29)) >> 30)));
      s5_in.vz_hi   = 52'(s4_ff.zb[41:21]) * 52'(s4_ff.s_mag);
      s5_in.vz_lo   = 52'(s4_ff.zb[20:0]) * 52'(s4_ff.s_mag);
      s5_in.s_neg   = s4_ff.s_neg;
      s5_in.pos_z   = s4_ff.pos_z;
      s5_in.vel_x   = s4_ff.vel_x;
      s5_in.vel_y   = s4_ff.vel_y;
      s5_in.start_x = s4_ff.start_x;
      s5_in.start_y = s4_ff.start_y;
   end

   // Stage 6: add start points, finish z velocity, saturate
   always_comb begin
      vz_sum = (74'(s5_ff.vz_hi) << 21) + 74'(s5_ff.vz_lo) + (74'(1) << 29);
      rsp_in.pos_x = sat32(48'(s5_ff.start_x) + 48'(s5_ff.px));
      rsp_in.pos_y = sat32(48'(s5_ff.start_y) + 48'(s5_ff.py));
      rsp_in.pos_z = s5_ff.pos_z;
      rsp_in.vel_x = s5_ff.vel_x;
      rsp_in.vel_y = s5_ff.vel_y;
      rsp_in.vel_z = sat32(apply_sign(s5_ff.s_neg, 47'(vz_sum >> 30)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
         rate_ff   <= SWING_RATE_RST;
         vld_ff    <= '0;
      end else begin
         height_ff <= height_in;
         rate_ff   <= rate_in;
         vld_ff    <= vld_in;
      end
   end

   // Payload stages carry no reset
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      s5_ff  <= s5_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_data  = rsp_ff;

   // Every accepted transaction yields a response strobe, and no strobe comes without one
   `CST_ASSERT_DELAY(a_rsp_follows_req, clock, reset, start && !busy, 6, rsp_valid)
   `CST_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, 6))
   // 1 - cos never exceeds two in Q30
   `CST_ASSERT_IMPLY(a_omc_range, clock, reset, vld_ff[1], s2_ff.trig.omc <= 32'h8000_0000)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the cycloid swing trajectory pipeline
`timescale 1ns / 100ps

import cst_pkg::*;

// Trajectory predictor plus the queue of expected foot states
class trajectory_scoreboard;
   rsp_type         pending_states[$];
   logic [63:0]     lift_height;
   logic [63:0]     swing_rate;
   logic [63:0]     sine_quarter[0:256];
   int              mismatches;

   function new();
      logic [63:0]        ang;
      logic [63:0]        term;
      logic signed [63:0] acc;
      lift_height = 0;
      swing_rate  = 291271;
      mismatches  = 0;
      for (int i = 0; i <= 256; i++) begin
         ang  = (64'(i) * 64'd1686629713 + 64'd128) / 64'd256;
         term = ang;
         acc  = $signed(ang);
         for (int k = 1; k <= 7; k++) begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - $signed(term);
            end else begin
               acc = acc + $signed(term);
            end
         end
         if (acc < 0) acc = 0;
         if (acc > 64'sd1073741824) acc = 64'sd1073741824;
         sine_quarter[i] = acc;
      end
   endfunction

   function void set_register(csr_index_type idx, logic [30:0] value);
      if (idx == CSR_SWING_HEIGHT) begin
         lift_height = 64'(value);
      end else begin
         swing_rate = 64'(value[23:0]);
      end
   endfunction

   // (a*b) >> s, rounded to nearest, half up
   function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
      return 64'(prod >> s);
   endfunction

   // Signed product on magnitudes, half rounds away from zero
   function logic signed [63:0] signed_round_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b, int s);
      logic [63:0] m;
      m = round_mul(a < 0 ? -a : a, b < 0 ? -b : b, s);
      return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   function logic signed [63:0] folded_sine(logic [1:0] quad, int idx);
      case (quad)
         2'd0: return $signed(sine_quarter[idx]);
         2'd1: return $signed(sine_quarter[256 - idx]);
         2'd2: return -$signed(sine_quarter[idx]);
         default: return -$signed(sine_quarter[256 - idx]);
      endcase
   endfunction

   function void note_request(req_type req);
      rsp_type            want;
      logic [1:0]         quad;
      int                 idx;
      logic signed [63:0] sn, cs, one_minus_cos, lateral, dx, dy, amp;
      quad = req.phase[15:14];
      idx  = (int'(req.phase[13:0]) * 256 + (1 << 13)) >> 14;
      sn   = folded_sine(quad, idx);
      cs   = folded_sine(quad + 2'd1, idx);
      one_minus_cos = 64'sd1073741824 - cs;
      lateral = $signed(64'(req.phase) << 14) - signed_round_mul(sn, 64'sd683565276, 32);
      dx = 64'(req.end_x) - 64'(req.start_x);
      dy = 64'(req.end_y) - 64'(req.start_y);
      want.pos_x = clamp32(64'(req.start_x) + signed_round_mul(dx, lateral, 30));
      want.pos_y = clamp32(64'(req.start_y) + signed_round_mul(dy, lateral, 30));
      want.pos_z = clamp32(64'(req.start_z) +
                           $signed(round_mul(lift_height, one_minus_cos, 31)));
      want.vel_x = clamp32(signed_round_mul(signed_round_mul(dx, $signed(swing_rate), 16),
                                            one_minus_cos, 30));
      want.vel_y = clamp32(signed_round_mul(signed_round_mul(dy, $signed(swing_rate), 16),
                                            one_minus_cos, 30));
      amp = $signed(round_mul(round_mul(lift_height, swing_rate, 16), 64'd3373259426, 30));
      want.vel_z = clamp32(signed_round_mul(amp, sn, 30));
      pending_states.push_back(want);
   endfunction

   function void compare_field(string label, logic signed [31:0] want,
                               logic signed [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_states.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         return;
      end
      want = pending_states.pop_front();
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("pos_z", want.pos_z, got.pos_z);
      compare_field("vel_x", want.vel_x, got.vel_x);
      compare_field("vel_y", want.vel_y, got.vel_y);
      compare_field("vel_z", want.vel_z, got.vel_z);
   endfunction
endclass

module testbench;
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_SWING_HEIGHT;
   logic [30:0]   csr_wdata = '0;

   trajectory_scoreboard trajectories = new();
   int            sender_idle_pct = 0;

   cycloid_swing_trajectory_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Results cannot be held off: take every strobe at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         trajectories.check_result(rsp_data);
      end
   end

   // Idle the request side for a random number of cycles, drop start meanwhile
   task automatic sender_gap();
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Present one transaction and hold it until the block takes it
   task automatic send_request(req_type req);
      sender_gap();
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      trajectories.note_request(req);
   endtask

   // Let the pipeline run dry so the registers can be rewritten safely
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (trajectories.pending_states.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // One write strobe; the task returns only after the strobe has been low at a clock edge
   task automatic write_register(csr_index_type idx, logic [30:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      trajectories.set_register(idx, value);
      @(posedge clock);
   endtask

   // Coordinates: mostly a few metres around the origin, sometimes full range
   function automatic logic signed [31:0] coordinate();
      if ($urandom_range(3) == 0) return $signed($urandom);
      return $signed(32'($urandom_range(1 << 19)) - 32'(1 << 18));
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.phase   = 16'($urandom);
      r.start_x = coordinate();
      r.start_y = coordinate();
      r.start_z = coordinate();
      r.end_x   = coordinate();
      r.end_y   = coordinate();
      return r;
   endfunction

   initial begin
      req_type     r;
      logic [15:0] corner_phases[7] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                                        16'hC000, 16'hFFFF, 16'h0020};
      int          idle_by_phase[5] = '{0, 70, 0, 38, 0};

      // Hold reset from time zero, then release it on a rising edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset register values: quadrant corners and rounding
      // points, with random coordinates
      foreach (corner_phases[i]) begin
         r = random_request();
         r.phase = corner_phases[i];
         send_request(r);
      end
      drain();

      // Largest height and rate: drive the velocities into saturation
      write_register(CSR_SWING_HEIGHT, 31'h7FFF_FFFF);
      write_register(CSR_SWING_RATE, 31'h7FFF_FFFF);
      for (int i = 0; i < 12; i++) begin
         r.phase   = corner_phases[i % 7] ^ 16'(i / 7);
         r.start_x = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         r.end_x   = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         r.start_y = (i % 3 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         r.end_y   = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         r.start_z = (i % 4 < 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         send_request(r);
      end
      drain();

      // Random part: each phase changes the registers and the sender's gaps
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               write_register(CSR_SWING_HEIGHT, 31'd0);
               write_register(CSR_SWING_RATE, 31'd0);
            end
            1: begin
               write_register(CSR_SWING_HEIGHT, 31'd6554);
               write_register(CSR_SWING_RATE, 31'd291271);
            end
            2: begin
               write_register(CSR_SWING_HEIGHT, 31'($urandom));
               write_register(CSR_SWING_RATE, 31'($urandom));
            end
            3: begin
               write_register(CSR_SWING_HEIGHT, 31'h7FFF_FFFF);
               write_register(CSR_SWING_RATE, 31'($urandom_range(1 << 20)));
            end
            default: begin
               write_register(CSR_SWING_HEIGHT, 31'($urandom_range(1 << 17)));
               write_register(CSR_SWING_RATE, 31'h00FF_FFFF);
            end
         endcase
         sender_idle_pct = idle_by_phase[p];
         for (int i = 0; i < 285; i++) begin
            send_request(random_request());
            // In phase 1 only, pause once mid-phase until every result is home
            if (p == 1 && i == 140) drain();
         end
         drain();
         sender_idle_pct = 0;
      end

      start <= 1'b0;
      while (trajectories.pending_states.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (trajectories.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
